@@ hw/rtl/sfdm_pkg.sv @@
// ----------------------------------------------------------------------------
// sfdm_pkg
// Shared types, constants and fixed-point helpers for the stereo feedback
// delay mix unit.
// ----------------------------------------------------------------------------
package sfdm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DELAY_W     = 15;
  localparam int FB_W        = 16;
  localparam int MIX_W       = 17;
  localparam int CFG_DW      = 17;
  localparam int CFG_IW      = 2;
  localparam int PROD_W      = 35;
  localparam int RND_W       = PROD_W - 16;

  localparam logic [FB_W-1:0]  FB_LIMIT = 16'd62259;
  localparam logic [MIX_W-1:0] MIX_ONE  = 17'd65536;

  localparam logic [CFG_IW-1:0] REG_DELAY    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FEEDBACK = 2'd1;
  localparam logic [CFG_IW-1:0] REG_WET_MIX  = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [RND_W-1:0]       rnd_t;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } in_item_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_item_t;

  // per-cycle lane control from the sequencing logic
  typedef struct packed {
    logic acc;      // item accepted: issue ring read, load stage 1
    logic zero;     // wet tap reads as zero (unwritten entry or bypass)
    logic fwd;      // wet tap is the sample written at this same edge
    logic commit;   // stage 1 retires: ring write, feedback state update
    logic s2_load;  // stage 2 takes the mix products
  } lane_ctl_t;

  // floor((p + 2^15) / 2^16)
  function automatic rnd_t round_q16(prod_t p);
    prod_t t;
    t = p + prod_t'(32768);
    return rnd_t'(t >>> 16);
  endfunction

  function automatic sample_t sat_sample(rnd_t v);
    sample_t s;
    if (v > rnd_t'(SAMPLE_MAX)) begin
      s = SAMPLE_MAX;
    end else if (v < rnd_t'(SAMPLE_MIN)) begin
      s = SAMPLE_MIN;
    end else begin
      s = sample_t'(v);
    end
    return s;
  endfunction

endpackage

@@ hw/rtl/sfdm_lane.sv @@
// ----------------------------------------------------------------------------
// sfdm_lane
// One channel: ring buffer, feedback loop and wet/dry mix products.
// ----------------------------------------------------------------------------
module sfdm_lane #(
  parameter int MAX_DELAY = 32768
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sfdm_pkg::lane_ctl_t            ctl,
  input  logic [$clog2(MAX_DELAY)-1:0]   rd_addr,
  input  logic [$clog2(MAX_DELAY)-1:0]   wr_addr,
  input  logic [sfdm_pkg::FB_W-1:0]      fb,
  input  logic [sfdm_pkg::MIX_W-1:0]     mix,
  input  sfdm_pkg::sample_t              sample_in,
  output sfdm_pkg::sample_t              sample_out
);
  import sfdm_pkg::*;

  sample_t ring [MAX_DELAY];

  sample_t rdata_r;
  sample_t dry_r;
  sample_t fwd_data_r;
  logic    zero_r;
  logic    fwd_r;

  sample_t                     last_wet_r, last_wet_nxt;
  logic signed [FB_W+FB_W:0]   fb_prod_r, fb_prod_nxt;
  prod_t                       wet_prod_r, dry_prod_r;

  sample_t                 wet;
  sample_t                 fed;
  logic signed [FB_W:0]    fb_s;
  logic signed [MIX_W:0]   mix_s;
  logic signed [MIX_W:0]   dry_s;
  prod_t                   wet_mix_prod;
  prod_t                   dry_mix_prod;

  always_comb begin
    if (fwd_r) begin
      wet = fwd_data_r;
    end else if (zero_r) begin
      wet = '0;
    end else begin
      wet = rdata_r;
    end
    fed          = sat_sample(rnd_t'(dry_r) + round_q16(prod_t'(fb_prod_r)));
    last_wet_nxt = ctl.commit ? wet : last_wet_r;
    fb_s         = $signed({1'b0, fb});
    fb_prod_nxt  = (FB_W+FB_W+1)'(last_wet_nxt) * (FB_W+FB_W+1)'(fb_s);
    mix_s        = $signed({1'b0, mix});
    dry_s        = $signed({1'b0, MIX_ONE - mix});
    wet_mix_prod = prod_t'(wet) * prod_t'(mix_s);
    dry_mix_prod = prod_t'(dry_r) * prod_t'(dry_s);
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      ring[wr_addr] <= fed;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      rdata_r <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      dry_r      <= sample_in;
      zero_r     <= ctl.zero;
      fwd_r      <= ctl.fwd;
      fwd_data_r <= fed;
    end
    if (ctl.s2_load) begin
      wet_prod_r <= wet_mix_prod;
      dry_prod_r <= dry_mix_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_wet_r <= '0;
      fb_prod_r  <= '0;
    end else begin
      last_wet_r <= last_wet_nxt;
      fb_prod_r  <= fb_prod_nxt;
    end
  end

  assign sample_out = sat_sample(round_q16(wet_prod_r + dry_prod_r));

endmodule

@@ hw/rtl/stereo_feedback_delay_mix_unit.sv @@
// ----------------------------------------------------------------------------
// stereo_feedback_delay_mix_unit
// Stereo feedback echo with wet/dry mix: two channel lanes, shared ring
// addressing, output register joining the lanes into one item.
// ----------------------------------------------------------------------------
// Takes one stereo pair per clock while the output is not stalled and returns
// one mixed pair per item through stage 1, stage 2 and the output register,
// in order. Each channel keeps a ring of MAX_DELAY 16-bit samples with one
// read and one write port; the pair rate is bounded by the feedback loop, one
// multiply then one add and saturate per item. A fill flag makes ring entries
// that were never written read as zero, so reset takes effect at once with no
// clearing pass. Write the configuration only while no item is in flight.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_mix_unit #(
  parameter int MAX_DELAY = 32768
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sfdm_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sfdm_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [sfdm_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [sfdm_pkg::CFG_DW-1:0]   cfg_wdata
);
  import sfdm_pkg::*;

  localparam int AW = $clog2(MAX_DELAY);

  logic [DELAY_W-1:0] delay_r;
  logic [FB_W-1:0]    fb_r;
  logic [MIX_W-1:0]   mix_r;

  logic [AW-1:0] wp_r, wp_nxt;
  logic          wrapped_r, wrapped_nxt;
  logic          v1_r, v1_nxt;
  logic          v2_r, v2_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r;

  logic [FB_W-1:0]  fb_eff;
  logic [MIX_W-1:0] mix_eff;
  logic [AW-1:0]    d_eff;
  logic [AW-1:0]    rd_addr;
  logic             bypass;
  logic             out_load;
  logic             s2_load;
  logic             acc;
  logic             commit;
  logic             wrap_now;
  lane_ctl_t        ctl;
  sample_t          left_mix;
  sample_t          right_mix;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_W'(1);
      fb_r    <= '0;
      mix_r   <= MIX_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELAY:    delay_r <= cfg_wdata[DELAY_W-1:0];
        REG_FEEDBACK: fb_r    <= cfg_wdata[FB_W-1:0];
        REG_WET_MIX:  mix_r   <= cfg_wdata[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fb_eff  = (fb_r > FB_LIMIT) ? FB_LIMIT : fb_r;
    mix_eff = (mix_r > MIX_ONE) ? MIX_ONE : mix_r;
    bypass  = (mix_eff == '0);
    if (delay_r == '0) begin
      d_eff = AW'(1);
    end else if (32'(delay_r) > 32'(MAX_DELAY - 1)) begin
      d_eff = AW'(MAX_DELAY - 1);
    end else begin
      d_eff = AW'(delay_r);
    end
  end

  // pipeline flow
  always_comb begin
    out_load = v2_r && (!out_valid_r || out_ready);
    s2_load  = v1_r && (!v2_r || out_load);
    in_ready = !v1_r || s2_load;
    acc      = in_valid && in_ready;
    commit   = s2_load && !bypass;

    v1_nxt        = acc ? 1'b1 : (s2_load ? 1'b0 : v1_r);
    v2_nxt        = s2_load ? 1'b1 : (out_load ? 1'b0 : v2_r);
    out_valid_nxt = out_load ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);
  end

  // ring addressing; the read for the new item is offset from the write position as advanced by this edge's commit
  always_comb begin
    wrap_now    = commit && (wp_r == AW'(MAX_DELAY - 1));
    wrapped_nxt = wrapped_r || wrap_now;
    if (!commit) begin
      wp_nxt = wp_r;
    end else if (wrap_now) begin
      wp_nxt = '0;
    end else begin
      wp_nxt = wp_r + AW'(1);
    end
    if ({1'b0, wp_nxt} >= {1'b0, d_eff}) begin
      rd_addr = wp_nxt - d_eff;
    end else begin
      rd_addr = AW'({1'b0, wp_nxt} + (AW+1)'(MAX_DELAY) - {1'b0, d_eff});
    end
    ctl.acc     = acc;
    ctl.zero    = bypass || (!wrapped_nxt && (wp_nxt < d_eff));
    ctl.fwd     = commit && (wp_r == rd_addr);
    ctl.commit  = commit;
    ctl.s2_load = s2_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      wrapped_r   <= wrapped_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  sfdm_lane #(
    .MAX_DELAY (MAX_DELAY)
  ) u_lane_left (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wp_r),
    .fb         (fb_eff),
    .mix        (mix_eff),
    .sample_in  (in_data.left_in),
    .sample_out (left_mix)
  );

  sfdm_lane #(
    .MAX_DELAY (MAX_DELAY)
  ) u_lane_right (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wp_r),
    .fb         (fb_eff),
    .mix        (mix_eff),
    .sample_in  (in_data.right_in),
    .sample_out (right_mix)
  );

  // merge lanes into the output item
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.left_out  <= left_mix;
      out_data_r.right_out <= right_mix;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_fwd_only_unit_delay: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fwd |-> (d_eff == AW'(1)))
    else $error("ring forward with delay other than one");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted item lost before stage 1");

  a_bypass_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (mix_eff == '0) |=> $stable(wp_r))
    else $error("write position moved in bypass");
`endif

endmodule
